// ===== rtl/aes_block_cipher_modes_assert.svh =====
// assertion macros for the rtl files, included by aesbcm_ctrl.sv
`ifndef AES_BLOCK_CIPHER_MODES_ASSERT_SVH
`define AES_BLOCK_CIPHER_MODES_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define AST_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("aes check failed");
`define AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("aes check failed");
`else
`define AST_SAME(lbl, ante, cons)
`define AST_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/aesbcm_pkg.sv =====
package aesbcm_pkg;

    localparam int BLOCK_COLUMNS = 4;
    localparam int ROW_W         = 32 * BLOCK_COLUMNS;
    localparam int ROWS          = 15;

    localparam logic [2:0] REG_KEY0     = 3'd0;
    localparam logic [2:0] REG_KEY1     = 3'd1;
    localparam logic [2:0] REG_KEY2     = 3'd2;
    localparam logic [2:0] REG_KEY3     = 3'd3;
    localparam logic [2:0] REG_KEY_SIZE = 3'd4;
    localparam logic [2:0] REG_IV_HIGH  = 3'd5;
    localparam logic [2:0] REG_IV_LOW   = 3'd6;
    localparam logic [2:0] REG_OP       = 3'd7;

    typedef enum logic [2:0] {
        OP_ECB_ENC = 3'd0,
        OP_ECB_DEC = 3'd1,
        OP_CBC_ENC = 3'd2,
        OP_CBC_DEC = 3'd3,
        OP_CFB_ENC = 3'd4,
        OP_CFB_DEC = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        KEY_128 = 2'd0,
        KEY_192 = 2'd1,
        KEY_256 = 2'd2
    } t_key_len;

    typedef enum logic [2:0] {
        S_IDLE, S_EXPAND, S_LOAD, S_INIT, S_ROUND, S_FINISH
    } t_state;

    typedef struct packed {
        logic     accept;
        logic     expand;
        logic     exp_from_key;
        logic     exp_sub_rot;
        logic     exp_sub_only;
        logic [5:0] exp_word;
        logic     init;
        logic     round;
        logic     last;
        logic     finish;
        logic     decrypt;
        logic [3:0] rk_addr;
        t_op      op;
        t_key_len key_len;
    } t_dp_cmd;

    localparam logic [2047:0] SBOX_FLAT = {
        128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
    };

    localparam logic [2047:0] INV_SBOX_FLAT = {
        128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
        128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
        128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
        128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
        128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
        128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
        128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
        128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d
    };

    function automatic logic [7:0] sub_byte(input logic [7:0] b);
        return SBOX_FLAT[{~b, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] inv_sub_byte(input logic [7:0] b);
        return INV_SBOX_FLAT[{~b, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sub_byte(w[31:24]), sub_byte(w[23:16]), sub_byte(w[15:8]), sub_byte(w[7:0])};
    endfunction

endpackage

// ===== rtl/aesbcm_ctrl.sv =====
`include "aes_block_cipher_modes_assert.svh"
module aesbcm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_stall,
    input  logic                i_cfg_wr,
    input  aesbcm_pkg::t_op     i_op,
    input  aesbcm_pkg::t_key_len i_key_len,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output aesbcm_pkg::t_dp_cmd o_cmd
);
    import aesbcm_pkg::*;

    t_state     r_state, n_state;
    logic [5:0] r_word, n_word;
    logic [2:0] r_mod, n_mod;
    logic [3:0] r_round, n_round;
    logic       r_keys_valid, n_keys_valid;
    logic       r_out_valid, n_out_valid;

    logic [3:0] nk, nr;
    logic [5:0] total;
    logic       dec, exp_done, last, out_free;

    always_comb begin
        unique case (i_key_len)
            KEY_128: begin nk = 4'd4; nr = 4'd10; end
            KEY_192: begin nk = 4'd6; nr = 4'd12; end
            default: begin nk = 4'd8; nr = 4'd14; end
        endcase
    end

    assign total    = {nr, 2'b00} + 6'd3;
    assign dec      = (i_op == OP_ECB_DEC) || (i_op == OP_CBC_DEC);
    assign exp_done = (r_word == total);
    assign last     = (r_round == nr);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = r_keys_valid ? S_LOAD : S_EXPAND;
            S_EXPAND: if (exp_done) n_state = S_LOAD;
            S_LOAD:   n_state = S_INIT;
            S_INIT:   n_state = S_ROUND;
            S_ROUND:  if (last) n_state = S_FINISH;
            S_FINISH: if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd              = '0;
        o_cmd.op           = i_op;
        o_cmd.key_len      = i_key_len;
        o_cmd.decrypt      = dec;
        o_cmd.exp_word     = r_word;
        o_cmd.exp_from_key = ({2'b00, r_word} < {4'd0, nk[3:0]} );
        o_cmd.exp_sub_rot  = (r_mod == 3'd0);
        o_cmd.exp_sub_only = (r_mod == 3'd4) && (i_key_len == KEY_256);
        o_cmd.last         = last;
        unique case (r_state)
            S_IDLE:   o_cmd.accept = i_in_valid;
            S_EXPAND: o_cmd.expand = 1'b1;
            S_LOAD:   o_cmd.rk_addr = dec ? nr : 4'd0;
            S_INIT: begin
                o_cmd.init    = 1'b1;
                o_cmd.rk_addr = dec ? nr - 4'd1 : 4'd1;
            end
            S_ROUND: begin
                o_cmd.round   = 1'b1;
                o_cmd.rk_addr = last ? 4'd0 : (dec ? nr - 4'd1 - r_round : r_round + 4'd1);
            end
            S_FINISH: o_cmd.finish = out_free;
            default:  o_cmd.accept = 1'b0;
        endcase
    end

    always_comb begin
        n_word       = r_word;
        n_mod        = r_mod;
        n_round      = r_round;
        n_keys_valid = r_keys_valid;
        n_out_valid  = r_out_valid;
        if (r_state == S_IDLE) begin
            n_word = '0;
            n_mod  = '0;
        end else if (r_state == S_EXPAND) begin
            n_word = r_word + 6'd1;
            n_mod  = ({1'b0, r_mod} == nk - 4'd1) ? 3'd0 : r_mod + 3'd1;
        end
        if (r_state == S_INIT) begin
            n_round = 4'd1;
        end else if (r_state == S_ROUND) begin
            n_round = r_round + 4'd1;
        end
        if (i_cfg_wr) begin
            n_keys_valid = 1'b0;
        end else if (r_state == S_EXPAND && exp_done) begin
            n_keys_valid = 1'b1;
        end
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_word       <= '0;
            r_mod        <= '0;
            r_round      <= '0;
            r_keys_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_word       <= n_word;
            r_mod        <= n_mod;
            r_round      <= n_round;
            r_keys_valid <= n_keys_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    `AST_NEXT(a_finish_sets_valid, o_cmd.finish, r_out_valid)
    `AST_NEXT(a_expand_sets_keys, r_state == S_EXPAND && exp_done && !i_cfg_wr, r_keys_valid)
    `AST_SAME(a_round_in_range, r_state == S_ROUND, r_round <= nr && r_round != 4'd0)
    `AST_NEXT(a_cold_start_expands, r_state == S_IDLE && i_in_valid && !r_keys_valid,
              r_state == S_EXPAND)
endmodule

// ===== rtl/aesbcm_dp.sv =====
module aesbcm_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  aesbcm_pkg::t_dp_cmd i_cmd,
    input  logic [63:0]         i_block_high,
    input  logic [63:0]         i_block_low,
    input  logic                i_first_block,
    input  logic [255:0]        i_key,
    input  logic [127:0]        i_iv,
    output logic [63:0]         o_result_high,
    output logic [63:0]         o_result_low
);
    import aesbcm_pkg::*;

    logic [ROW_W-1:0] r_rk_mem [ROWS];
    logic [ROW_W-1:0] r_rk_rd;
    logic [31:0]      r_win [8];
    logic [7:0]       r_rcon, n_rcon;
    logic [127:0]     r_blk, r_chain, r_cipher, r_result;
    logic [127:0]     n_chain, n_cipher;

    logic [31:0]  w_prev, w_back, w_temp, w_new, w_key;
    logic [127:0] core_in, rnd, fin;

    // key schedule, one word a cycle
    assign w_prev = r_win[7];
    always_comb begin
        unique case (i_cmd.key_len)
            KEY_128: w_back = r_win[4];
            KEY_192: w_back = r_win[2];
            default: w_back = r_win[0];
        endcase
    end
    assign w_key = i_key[255 - 32 * i_cmd.exp_word[2:0] -: 32];

    always_comb begin
        n_rcon = r_rcon;
        w_temp = w_prev;
        if (i_cmd.exp_from_key) begin
            n_rcon = 8'h01;
            w_new  = w_key;
        end else begin
            if (i_cmd.exp_sub_rot) begin
                w_temp = sub_word({w_prev[23:0], w_prev[31:24]}) ^ {r_rcon, 24'h0};
                n_rcon = xtime(r_rcon);
            end else if (i_cmd.exp_sub_only) begin
                w_temp = sub_word(w_prev);
            end
            w_new = w_back ^ w_temp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.expand) begin
            for (int k = 0; k < 7; k++) r_win[k] <= r_win[k + 1];
            r_win[7] <= w_new;
            r_rcon   <= n_rcon;
            if (i_cmd.exp_word[1:0] == 2'b11)
                r_rk_mem[i_cmd.exp_word[5:2]] <= {r_win[5], r_win[6], r_win[7], w_new};
        end
        r_rk_rd <= r_rk_mem[i_cmd.rk_addr];
    end

    // one cipher round
    always_comb begin
        logic [127:0] sb, sr;
        logic [7:0]   a0, a1, a2, a3, x2, x4, x8;
        sb  = '0;
        sr  = '0;
        rnd = '0;
        if (!i_cmd.decrypt) begin
            for (int k = 0; k < 16; k++) sb[127 - 8 * k -: 8] = sub_byte(r_cipher[127 - 8 * k -: 8]);
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    sr[127 - 8 * (4 * c + r) -: 8] = sb[127 - 8 * (4 * ((c + r) % 4) + r) -: 8];
            for (int c = 0; c < 4; c++) begin
                a0 = sr[127 - 32 * c -: 8];
                a1 = sr[119 - 32 * c -: 8];
                a2 = sr[111 - 32 * c -: 8];
                a3 = sr[103 - 32 * c -: 8];
                if (i_cmd.last) begin
                    rnd[127 - 32 * c -: 32] = {a0, a1, a2, a3};
                end else begin
                    rnd[127 - 32 * c -: 32] = {
                        xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                        a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                        a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                        xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
                end
            end
            rnd = rnd ^ r_rk_rd;
        end else begin
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    sr[127 - 8 * (4 * c + r) -: 8] = r_cipher[127 - 8 * (4 * ((c + 4 - r) % 4) + r) -: 8];
            for (int k = 0; k < 16; k++) sb[127 - 8 * k -: 8] = inv_sub_byte(sr[127 - 8 * k -: 8]);
            sb = sb ^ r_rk_rd;
            for (int c = 0; c < 4; c++) begin
                logic [7:0] m [4];
                for (int r = 0; r < 4; r++) m[r] = sb[127 - 32 * c - 8 * r -: 8];
                if (i_cmd.last) begin
                    rnd[127 - 32 * c -: 32] = {m[0], m[1], m[2], m[3]};
                end else begin
                    for (int r = 0; r < 4; r++) begin
                        logic [7:0] acc;
                        acc = '0;
                        for (int k = 0; k < 4; k++) begin
                            x2 = xtime(m[k]);
                            x4 = xtime(x2);
                            x8 = xtime(x4);
                            unique case ((k + 4 - r) % 4)
                                0:       acc = acc ^ x8 ^ x4 ^ x2;
                                1:       acc = acc ^ x8 ^ x2 ^ m[k];
                                2:       acc = acc ^ x8 ^ x4 ^ m[k];
                                default: acc = acc ^ x8 ^ m[k];
                            endcase
                        end
                        rnd[127 - 32 * c - 8 * r -: 8] = acc;
                    end
                end
            end
        end
    end

    // mode chaining around the block cipher
    always_comb begin
        unique case (i_cmd.op)
            OP_CBC_ENC:             core_in = r_blk ^ r_chain;
            OP_CFB_ENC, OP_CFB_DEC: core_in = r_chain;
            default:                core_in = r_blk;
        endcase
        unique case (i_cmd.op)
            OP_CBC_DEC:             fin = r_cipher ^ r_chain;
            OP_CFB_ENC, OP_CFB_DEC: fin = r_cipher ^ r_blk;
            default:                fin = r_cipher;
        endcase
        n_chain = r_chain;
        if (i_cmd.accept && i_first_block) begin
            n_chain = i_iv;
        end else if (i_cmd.finish) begin
            unique case (i_cmd.op)
                OP_CBC_ENC, OP_CFB_ENC: n_chain = fin;
                OP_CBC_DEC, OP_CFB_DEC: n_chain = r_blk;
                default:                n_chain = r_chain;
            endcase
        end
        n_cipher = r_cipher;
        if (i_cmd.init) begin
            n_cipher = core_in ^ r_rk_rd;
        end else if (i_cmd.round) begin
            n_cipher = rnd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= '0;
        end else begin
            r_chain <= n_chain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cipher <= n_cipher;
        if (i_cmd.accept) r_blk <= {i_block_high, i_block_low};
        if (i_cmd.finish) r_result <= fin;
    end

    assign o_result_high = r_result[127:64];
    assign o_result_low  = r_result[63:0];
endmodule

// ===== rtl/aes_block_cipher_modes.sv =====
// aes in ecb, cbc or cfb mode, encrypt and decrypt, 128/192/256 bit keys
// steps: accept, round key load, initial key add, nr rounds (nr = 10, 12 or 14), result,
//   preceded by key expansion on the first block after reset or a register write
// one block at a time through the single shared round unit; input stalls until the result is registered
// reset: synchronous active low; clears the register file, controller state, chaining value and key-valid flag
module aes_block_cipher_modes (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input block channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [63:0] i_block_high,
    input  logic [63:0] i_block_low,
    input  logic        i_first_block,
    // result block channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_result_high,
    output logic [63:0] o_result_low,
    // register port, 64-bit registers at 8 byte steps
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import aesbcm_pkg::*;

    logic [63:0] r_key0, r_key1, r_key2, r_key3, r_iv_high, r_iv_low;
    logic [1:0]  r_key_size;
    logic [2:0]  r_operation;

    logic        cfg_wr;
    logic [2:0]  reg_idx;
    t_op         op;
    t_key_len    key_len;
    t_dp_cmd     cmd;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // register file; every write forces a fresh key expansion
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0      <= '0;
            r_key1      <= '0;
            r_key2      <= '0;
            r_key3      <= '0;
            r_key_size  <= '0;
            r_iv_high   <= '0;
            r_iv_low    <= '0;
            r_operation <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_KEY0:     r_key0      <= pwdata;
                REG_KEY1:     r_key1      <= pwdata;
                REG_KEY2:     r_key2      <= pwdata;
                REG_KEY3:     r_key3      <= pwdata;
                REG_KEY_SIZE: r_key_size  <= pwdata[1:0];
                REG_IV_HIGH:  r_iv_high   <= pwdata;
                REG_IV_LOW:   r_iv_low    <= pwdata;
                REG_OP:       r_operation <= pwdata[2:0];
                default:      r_key0      <= r_key0;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_KEY0:     prdata = r_key0;
            REG_KEY1:     prdata = r_key1;
            REG_KEY2:     prdata = r_key2;
            REG_KEY3:     prdata = r_key3;
            REG_KEY_SIZE: prdata = {62'd0, r_key_size};
            REG_IV_HIGH:  prdata = r_iv_high;
            REG_IV_LOW:   prdata = r_iv_low;
            REG_OP:       prdata = {61'd0, r_operation};
            default:      prdata = '0;
        endcase
    end

    // unused operation codes run as ecb encryption, unused key size as 256 bit
    always_comb begin
        unique case (r_operation)
            3'd1:    op = OP_ECB_DEC;
            3'd2:    op = OP_CBC_ENC;
            3'd3:    op = OP_CBC_DEC;
            3'd4:    op = OP_CFB_ENC;
            3'd5:    op = OP_CFB_DEC;
            default: op = OP_ECB_ENC;
        endcase
        unique case (r_key_size)
            2'd0:    key_len = KEY_128;
            2'd1:    key_len = KEY_192;
            default: key_len = KEY_256;
        endcase
    end

    // sequencer: expansion, key load, initial key add, rounds, result hand-off
    aesbcm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_cfg_wr    (cfg_wr),
        .i_op        (op),
        .i_key_len   (key_len),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // round unit, round key memory and chaining value
    aesbcm_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_block_high  (i_block_high),
        .i_block_low   (i_block_low),
        .i_first_block (i_first_block),
        .i_key         ({r_key0, r_key1, r_key2, r_key3}),
        .i_iv          ({r_iv_high, r_iv_low}),
        .o_result_high (o_result_high),
        .o_result_low  (o_result_low)
    );
endmodule
